/* rtl/matrix_inverse_3x3_defines.svh */
// Assertion macros for the matrix_inverse_3x3 RTL files; mi3_fifo uses them.
// Needs a clock named clock and a reset named reset in the module that uses them.
`ifndef MATRIX_INVERSE_3X3_DEFINES_SVH
`define MATRIX_INVERSE_3X3_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MI3_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("matrix_inverse_3x3 assertion failed");

// Next-cycle implication, disabled during reset.
`define MI3_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("matrix_inverse_3x3 assertion failed");

`endif

/* rtl/mi3_pkg.sv */
// Package for the 3x3 matrix inverter: widths, payload types and queue entry type.
// No dependencies.
`timescale 1ns / 1ps

package mi3_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int ELEM_W     = 32;
   localparam int NUM_ELEM   = 9;
   localparam int ADJ_W      = 65;
   localparam int DET_W      = 97;
   localparam int MAG_W      = 96;
   localparam int REM_W      = MAG_W + 1;
   localparam int CMAG_W     = 64;
   localparam int NUM_W      = CMAG_W + 2 * FRAC_BITS;
   localparam int QUO_W      = 32;
   localparam int FRONT_LAT  = 6;
   localparam int BACK_LAT   = QUO_W + 3;
   localparam int FIFO_DEPTH = 2;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam logic [QUO_W-1:0] SAT_POS = {1'b0, {(QUO_W-1){1'b1}}};
   localparam logic [QUO_W-1:0] SAT_NEG = {1'b1, {(QUO_W-1){1'b0}}};

   typedef struct packed {
      logic signed [ELEM_W-1:0] a00;
      logic signed [ELEM_W-1:0] a01;
      logic signed [ELEM_W-1:0] a02;
      logic signed [ELEM_W-1:0] a10;
      logic signed [ELEM_W-1:0] a11;
      logic signed [ELEM_W-1:0] a12;
      logic signed [ELEM_W-1:0] a20;
      logic signed [ELEM_W-1:0] a21;
      logic signed [ELEM_W-1:0] a22;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] b00;
      logic signed [ELEM_W-1:0] b01;
      logic signed [ELEM_W-1:0] b02;
      logic signed [ELEM_W-1:0] b10;
      logic signed [ELEM_W-1:0] b11;
      logic signed [ELEM_W-1:0] b12;
      logic signed [ELEM_W-1:0] b20;
      logic signed [ELEM_W-1:0] b21;
      logic signed [ELEM_W-1:0] b22;
      logic                     singular;
   } rsp_type;

   typedef struct packed {
      logic [NUM_ELEM-1:0][ADJ_W-1:0] adj;
      logic [DET_W-1:0]               det;
   } entry_type;

endpackage

/* rtl/mi3_front.sv */
// Front pipeline: accepts matrices, forms the adjugate and the exact determinant.
// Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mi3_pkg::req_type   req_data,
   output logic               push,
   output mi3_pkg::entry_type push_data,
   input  logic               full
);
   import mi3_pkg::*;

   localparam logic [3:0] MP [NUM_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam logic [3:0] MQ [NUM_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam logic [3:0] MR [NUM_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam logic [3:0] MS [NUM_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   logic                      adv;
   logic [FRONT_LAT-1:0]      v_ff, v_in;
   req_type                   in_ff;
   logic signed [ELEM_W-1:0]  elem [NUM_ELEM];
   logic signed [2*ELEM_W-1:0] pq_ff [NUM_ELEM];
   logic signed [2*ELEM_W-1:0] rs_ff [NUM_ELEM];
   logic signed [ELEM_W-1:0]  r1_ff [3];
   logic signed [ELEM_W-1:0]  r2_ff [3];
   logic signed [ADJ_W-1:0]   adj2_ff [NUM_ELEM];
   logic signed [ADJ_W-1:0]   adj3_ff [NUM_ELEM];
   logic signed [ADJ_W-1:0]   adj4_ff [NUM_ELEM];
   logic signed [ADJ_W-1:0]   adj5_ff [NUM_ELEM];
   logic signed [ADJ_W-1:0]   pl_ff [3];
   logic signed [ADJ_W-1:0]   ph_ff [3];
   logic signed [DET_W-1:0]   term_ff [3];
   logic signed [DET_W-1:0]   det_ff, det_in;

   assign adv       = !v_ff[FRONT_LAT-1] || !full;
   assign req_ready = adv;
   assign push      = v_ff[FRONT_LAT-1] && !full;
   assign v_in      = {v_ff[FRONT_LAT-2:0], req_valid};

   assign elem[0] = in_ff.a00;
   assign elem[1] = in_ff.a01;
   assign elem[2] = in_ff.a02;
   assign elem[3] = in_ff.a10;
   assign elem[4] = in_ff.a11;
   assign elem[5] = in_ff.a12;
   assign elem[6] = in_ff.a20;
   assign elem[7] = in_ff.a21;
   assign elem[8] = in_ff.a22;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff <= req_data;
      end
   end

   for (genvar k = 0; k < NUM_ELEM; k++) begin : g_minor
      logic signed [ADJ_W-1:0] adj_in;
      assign adj_in = ADJ_W'(pq_ff[k]) - ADJ_W'(rs_ff[k]);
      always_ff @(posedge clock) begin
         if (adv) begin
            pq_ff[k]   <= elem[MP[k]] * elem[MQ[k]];
            rs_ff[k]   <= elem[MR[k]] * elem[MS[k]];
            adj2_ff[k] <= adj_in;
            adj3_ff[k] <= adj2_ff[k];
            adj4_ff[k] <= adj3_ff[k];
            adj5_ff[k] <= adj4_ff[k];
         end
      end
   end

   for (genvar j = 0; j < 3; j++) begin : g_det
      logic signed [ADJ_W-1:0] pl_in, ph_in;
      logic signed [DET_W-1:0] term_in;
      assign pl_in   = r2_ff[j] * $signed({1'b0, adj2_ff[3*j][31:0]});
      assign ph_in   = r2_ff[j] * $signed(adj2_ff[3*j][ADJ_W-1:32]);
      assign term_in = (DET_W'(ph_ff[j]) <<< 32) + DET_W'(pl_ff[j]);
      always_ff @(posedge clock) begin
         if (adv) begin
            r1_ff[j]   <= elem[j];
            r2_ff[j]   <= r1_ff[j];
            pl_ff[j]   <= pl_in;
            ph_ff[j]   <= ph_in;
            term_ff[j] <= term_in;
         end
      end
   end

   assign det_in = term_ff[0] + term_ff[1] + term_ff[2];

   always_ff @(posedge clock) begin
      if (adv) begin
         det_ff <= det_in;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_ELEM; k++) begin
         push_data.adj[k] = adj5_ff[k];
      end
      push_data.det = det_ff;
   end

endmodule

/* rtl/mi3_fifo.sv */
// Two-entry queue between the front and back pipelines.
// Depends on mi3_pkg and matrix_inverse_3x3_defines.svh.
`timescale 1ns / 1ps
`include "matrix_inverse_3x3_defines.svh"

module mi3_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mi3_pkg::entry_type wdata,
   output logic               full,
   input  logic               pop,
   output mi3_pkg::entry_type rdata,
   output logic               empty
);
   import mi3_pkg::*;

   entry_type         mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wptr_ff, wptr_in;
   logic [PTR_W-1:0]  rptr_ff, rptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full  = count_ff == CNT_W'(FIFO_DEPTH);
   assign empty = count_ff == '0;
   assign rdata = mem_ff[rptr_ff];

   assign wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
   assign rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
   assign count_in = count_ff + CNT_W'(push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

   `MI3_ASSERT_IMPL(a_push_has_room, push, !full)
   `MI3_ASSERT_IMPL(a_pop_has_data, pop, !empty)
   `MI3_ASSERT_NEXT(a_count_tracks, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

/* rtl/mi3_lane.sv */
// One inverse element: magnitude, overflow check, 32 restoring divide stages, saturation.
// Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_lane (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [mi3_pkg::ADJ_W-1:0] cof_in,
   input  logic signed [mi3_pkg::DET_W-1:0] det_in,
   output logic [mi3_pkg::QUO_W-1:0]        b_out
);
   import mi3_pkg::*;

   logic                  neg0_ff, neg0_in;
   logic [CMAG_W-1:0]     cmag0_ff, cmag0_in;
   logic [MAG_W-1:0]      dmag0_ff, dmag0_in;
   logic [ADJ_W-1:0]      cabs;
   logic [DET_W-1:0]      dabs;
   logic [NUM_W-1:0]      num;
   logic [NUM_W-33:0]     num_hi;

   logic [REM_W-1:0]      rem_ff [QUO_W+1];
   logic [31:0]           lo_ff  [QUO_W+1];
   logic [QUO_W-1:0]      q_ff   [QUO_W+1];
   logic [MAG_W-1:0]      d_ff   [QUO_W+1];
   logic                  neg_ff [QUO_W+1];
   logic                  ovf_ff [QUO_W+1];

   logic [QUO_W-1:0]      qf;
   logic                  sat;
   logic [QUO_W-1:0]      b_ff, b_in;

   assign cabs     = cof_in[ADJ_W-1] ? ADJ_W'(-cof_in) : cof_in;
   assign dabs     = det_in[DET_W-1] ? DET_W'(-det_in) : det_in;
   assign cmag0_in = cabs[CMAG_W-1:0];
   assign dmag0_in = dabs[MAG_W-1:0];
   assign neg0_in  = cof_in[ADJ_W-1] ^ det_in[DET_W-1];

   assign num    = {cmag0_ff, {(2*FRAC_BITS){1'b0}}};
   assign num_hi = num[NUM_W-1:32];

   always_ff @(posedge clock) begin
      if (en) begin
         neg0_ff   <= neg0_in;
         cmag0_ff  <= cmag0_in;
         dmag0_ff  <= dmag0_in;
         rem_ff[0] <= REM_W'(num_hi);
         lo_ff[0]  <= num[31:0];
         q_ff[0]   <= '0;
         d_ff[0]   <= dmag0_ff;
         neg_ff[0] <= neg0_ff;
         ovf_ff[0] <= REM_W'(num_hi) >= REM_W'(dmag0_ff);
      end
   end

   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      logic [REM_W-1:0] shifted;
      logic [REM_W:0]   diff;
      logic             take;
      assign shifted = {rem_ff[i][REM_W-2:0], lo_ff[i][31]};
      assign diff    = {1'b0, shifted} - {2'b00, d_ff[i]};
      assign take    = !diff[REM_W];
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1] <= take ? diff[REM_W-1:0] : shifted;
            lo_ff[i+1]  <= {lo_ff[i][30:0], 1'b0};
            q_ff[i+1]   <= {q_ff[i][QUO_W-2:0], take};
            d_ff[i+1]   <= d_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            ovf_ff[i+1] <= ovf_ff[i];
         end
      end
   end

   assign qf   = q_ff[QUO_W];
   assign sat  = ovf_ff[QUO_W] || (neg_ff[QUO_W] ? (qf > SAT_NEG) : qf[QUO_W-1]);
   assign b_in = sat ? (neg_ff[QUO_W] ? SAT_NEG : SAT_POS)
                     : (neg_ff[QUO_W] ? QUO_W'(-qf) : qf);

   always_ff @(posedge clock) begin
      if (en) begin
         b_ff <= b_in;
      end
   end

   assign b_out = b_ff;

endmodule

/* rtl/mi3_back.sv */
// Back pipeline: nine divide lanes, singular tracking and the result register.
// Depends on mi3_pkg and mi3_lane.
`timescale 1ns / 1ps

module mi3_back (
   input  logic               clock,
   input  logic               reset,
   input  mi3_pkg::entry_type rdata,
   input  logic               empty,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mi3_pkg::rsp_type   rsp_data
);
   import mi3_pkg::*;

   logic                    adv;
   logic [BACK_LAT-1:0]     v_ff, v_in;
   logic [BACK_LAT-1:0]     s_ff, s_in;
   logic [QUO_W-1:0]        b_w [NUM_ELEM];
   logic [QUO_W-1:0]        b_m [NUM_ELEM];
   logic                    sing;

   assign adv  = !v_ff[BACK_LAT-1] || rsp_ready;
   assign pop  = adv && !empty;
   assign v_in = {v_ff[BACK_LAT-2:0], !empty};
   assign s_in = {s_ff[BACK_LAT-2:0], rdata.det == '0};
   assign sing = s_ff[BACK_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff <= s_in;
      end
   end

   for (genvar k = 0; k < NUM_ELEM; k++) begin : g_lane
      mi3_lane u_lane (
         .clock  (clock),
         .en     (adv),
         .cof_in ($signed(rdata.adj[k])),
         .det_in ($signed(rdata.det)),
         .b_out  (b_w[k])
      );
      assign b_m[k] = sing ? '0 : b_w[k];
   end

   assign rsp_valid         = v_ff[BACK_LAT-1];
   assign rsp_data.b00      = b_m[0];
   assign rsp_data.b01      = b_m[1];
   assign rsp_data.b02      = b_m[2];
   assign rsp_data.b10      = b_m[3];
   assign rsp_data.b11      = b_m[4];
   assign rsp_data.b12      = b_m[5];
   assign rsp_data.b20      = b_m[6];
   assign rsp_data.b21      = b_m[7];
   assign rsp_data.b22      = b_m[8];
   assign rsp_data.singular = sing;

endmodule

/* rtl/matrix_inverse_3x3.sv */
// Top level of the 3x3 fixed-point matrix inverter.
// Depends on mi3_pkg, mi3_front, mi3_fifo and mi3_back.
//
// Usage: each req transaction carries one 3x3 matrix of signed Q16.16 elements;
// each rsp transaction carries the nine inverse elements in Q16.16, truncated
// toward zero and saturated, plus a singular flag that is set, with all
// elements zero, when the exact determinant is zero.
// Exactly one rsp transaction follows every req transaction, in order.
// From acceptance to rsp_valid a matrix passes through six front stages forming
// minors and determinant, the two-entry queue, and 35 back stages, of which 32
// are the restoring divide steps, one quotient bit each.
// Throughput is one matrix per cycle while rsp_ready stays high; every stage
// is fully pipelined.
// When rsp_ready is low the back pipeline holds, the queue fills, and then
// the front pipeline holds and req_ready drops. No transaction is lost.
// Synchronous reset empties all pipelines and the queue; payload registers
// are not cleared. There is no configuration.
`timescale 1ns / 1ps

module matrix_inverse_3x3 (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mi3_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mi3_pkg::rsp_type rsp_data
);
   import mi3_pkg::*;

   logic      push, full, pop, empty;
   entry_type push_data, rdata;

   mi3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   mi3_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (push_data),
      .full  (full),
      .pop   (pop),
      .rdata (rdata),
      .empty (empty)
   );

   mi3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rdata     (rdata),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/sv/tb_matrix_inverse_3x3.sv */
// Testbench for matrix_inverse_3x3: directed and random 3x3 matrices, with an exact
// wide-integer predictor of the saturated Q16.16 inverse and a random-stall handshake.
// Depends on mi3_pkg and the matrix_inverse_3x3 RTL.
`timescale 1ns / 1ps

module tb_matrix_inverse_3x3;
   import mi3_pkg::*;

   localparam int WIDE_W = 192;
   typedef logic signed [WIDE_W-1:0] wide_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_mats[$];
   rsp_type expected_invs[$];
   int      mismatches = 0;
   int      checked = 0;
   int      singular_seen = 0;
   int      saturated_seen = 0;
   int      accepted = 0;
   bit      stim_done = 1'b0;
   bit      hold_rsp = 1'b0;
   bit      drain_wait = 1'b0;
   bit      req_taken = 1'b0;
   int      send_gap = 0;
   int      recv_gap = 0;

   matrix_inverse_3x3 i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] scaled_quotient(wide_type num, wide_type den);
      logic     neg;
      wide_type n;
      wide_type d;
      wide_type q;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = (n <<< (2 * FRAC_BITS)) / d;
      if (!neg && q > 64'sh7FFFFFFF) return SAT_POS;
      if (neg && q > 64'sh80000000) return SAT_NEG;
      return neg ? 32'(-q) : 32'(q);
   endfunction

   function automatic rsp_type invert_matrix(req_type m);
      wide_type a [9];
      wide_type adj [9];
      wide_type det;
      rsp_type  r;
      a[0] = wide_type'(m.a00); a[1] = wide_type'(m.a01); a[2] = wide_type'(m.a02);
      a[3] = wide_type'(m.a10); a[4] = wide_type'(m.a11); a[5] = wide_type'(m.a12);
      a[6] = wide_type'(m.a20); a[7] = wide_type'(m.a21); a[8] = wide_type'(m.a22);
      adj[0] = a[4] * a[8] - a[5] * a[7];
      adj[1] = a[2] * a[7] - a[1] * a[8];
      adj[2] = a[1] * a[5] - a[2] * a[4];
      adj[3] = a[5] * a[6] - a[3] * a[8];
      adj[4] = a[0] * a[8] - a[2] * a[6];
      adj[5] = a[2] * a[3] - a[0] * a[5];
      adj[6] = a[3] * a[7] - a[4] * a[6];
      adj[7] = a[1] * a[6] - a[0] * a[7];
      adj[8] = a[0] * a[4] - a[1] * a[3];
      det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
      r = '0;
      if (det == 0) begin
         r.singular = 1'b1;
         return r;
      end
      r.b00 = scaled_quotient(adj[0], det); r.b01 = scaled_quotient(adj[1], det);
      r.b02 = scaled_quotient(adj[2], det); r.b10 = scaled_quotient(adj[3], det);
      r.b11 = scaled_quotient(adj[4], det); r.b12 = scaled_quotient(adj[5], det);
      r.b20 = scaled_quotient(adj[6], det); r.b21 = scaled_quotient(adj[7], det);
      r.b22 = scaled_quotient(adj[8], det);
      return r;
   endfunction

   function automatic logic [31:0] random_element(int style);
      case (style)
         0: return $urandom;
         1: return $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
         2: return ($urandom_range(0, 1) ? 32'h10000 : 32'hFFFF0000) * $urandom_range(0, 4);
         default: return $urandom_range(0, 15) - 8;
      endcase
   endfunction

   function automatic req_type random_matrix();
      req_type m;
      int      style;
      int      row;
      style = $urandom_range(0, 3);
      m = {random_element(style), random_element(style), random_element(style),
           random_element(style), random_element(style), random_element(style),
           random_element(style), random_element(style), random_element(style)};
      if ($urandom_range(0, 9) == 0) begin
         row = $urandom_range(0, 2);
         if (row == 0) begin
            m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
         end else if (row == 1) begin
            m.a10 = -m.a00; m.a11 = -m.a01; m.a12 = -m.a02;
         end else begin
            m.a02 = m.a00; m.a12 = m.a10; m.a22 = m.a20;
         end
      end
      return m;
   endfunction

   function automatic req_type diag_matrix(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
      req_type m;
      m = '0;
      m.a00 = d0; m.a11 = d1; m.a22 = d2;
      return m;
   endfunction

   always @(posedge clock) begin
      req_taken = !reset && req_valid && req_ready;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            expected_invs.push_back(invert_matrix(req_data));
            accepted++;
            void'(pending_mats.pop_front());
            send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
         end
         if (req_valid && !req_taken) begin
            req_valid <= 1'b1;
         end else if (drain_wait && expected_invs.size() != 0) begin
            req_valid <= 1'b0;
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_mats.size() != 0) begin
            req_valid <= 1'b1;
            req_data <= pending_mats[0];
         end else begin
            req_valid <= 1'b0;
         end
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap = $urandom_range(0, 16);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_invs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_data);
         end else begin
            want = expected_invs.pop_front();
            checked++;
            if (want.singular) singular_seen++;
            if (want.b00 == SAT_POS || want.b00 == SAT_NEG) saturated_seen++;
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch on response %0d: expected %h, got %h",
                           checked, want, rsp_data);
            end
         end
      end
   end

   initial begin
      repeat (8000) begin
         @(posedge clock);
         if (accepted >= 300 && accepted < 400) begin
            hold_rsp = 1'b1;
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
            break;
         end
      end
   end

   initial begin
      req_type m;
      pending_mats.push_back(diag_matrix(32'h10000, 32'h10000, 32'h10000));
      pending_mats.push_back(diag_matrix(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
      pending_mats.push_back(diag_matrix(32'h80000000, 32'h80000000, 32'h80000000));
      pending_mats.push_back(diag_matrix(32'h1, 32'h1, 32'h1));
      pending_mats.push_back(diag_matrix(32'hFFFFFFFF, 32'h1, 32'h10000));
      pending_mats.push_back(diag_matrix(32'h20000, 32'hFFFE0000, 32'h8000));
      pending_mats.push_back(diag_matrix(32'h30000, 32'h30000, 32'h30000));
      pending_mats.push_back('0);
      pending_mats.push_back({9{32'hFFFFFFFF}});
      pending_mats.push_back({9{32'h7FFFFFFF}});
      m = {32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h80000000, 32'h7FFFFFFF,
           32'h7FFFFFFF, 32'h0, 32'h80000000};
      pending_mats.push_back(m);
      m = {32'h10000, 32'h20000, 32'h30000, 32'h0, 32'h10000, 32'h40000,
           32'h50000, 32'h60000, 32'h0};
      pending_mats.push_back(m);
      m = {32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h0, 32'h0};
      pending_mats.push_back(m);
      m = {32'h0, 32'h0, 32'h10000, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0};
      pending_mats.push_back(m);
      m = {32'h20000, 32'h10000, 32'h0, 32'h10000, 32'h30000, 32'h10000,
           32'hFFFF0000, 32'h20000, 32'h40000};
      pending_mats.push_back(m);
      m = {32'h10000, 32'h20000, 32'h30000, 32'h40000, 32'h50000, 32'h60000,
           32'h70000, 32'h80000, 32'h90000};
      pending_mats.push_back(m);
      m = {32'hAAAAAAAA, 32'h55555555, 32'h0, 32'h55555555, 32'hAAAAAAAA, 32'h0,
           32'h0, 32'h0, 32'h1};
      pending_mats.push_back(m);
      repeat (1730) pending_mats.push_back(random_matrix());
      repeat (11) @(posedge clock);
      reset <= 1'b1;
      @(negedge clock);
      reset = 1'b0;
      wait (accepted >= 900);
      drain_wait = 1'b1;
      wait (expected_invs.size() == 0);
      @(negedge clock);
      drain_wait = 1'b0;
      wait (pending_mats.size() == 0 && expected_invs.size() == 0);
      repeat (60) @(posedge clock);
      $display("Checked %0d inverses, %0d singular and %0d saturated in the first element,",
               checked, singular_seen, saturated_seen);
      $display("with random stalls on both channels and a long receiver hold-off.");
      if (mismatches == 0 && expected_invs.size() == 0) begin
         $display("tb_matrix_inverse_3x3 passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_matrix_inverse_3x3 failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout");
      $display("tb_matrix_inverse_3x3 failed");
      $finish;
   end

endmodule
